### rtl/core/ip_flow_packet_byte_counter_top_assert.svh
// assertion macros for the flow counter
`ifndef IP_FLOW_PACKET_BYTE_COUNTER_TOP_ASSERT_SVH
`define IP_FLOW_PACKET_BYTE_COUNTER_TOP_ASSERT_SVH
// implication checked every clock edge outside reset
`define IPFC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define IPFC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/core/ipfc_pkg.sv
// shared types and constants of the flow counter
package ipfc_pkg;
  localparam int unsigned V4Entries = 1024;
  localparam int unsigned V6Entries = 1024;
  localparam int unsigned V4IdxW = (V4Entries > 1) ? $clog2(V4Entries) : 1;
  localparam int unsigned V6IdxW = (V6Entries > 1) ? $clog2(V6Entries) : 1;
  localparam int unsigned MaxEntries = (V4Entries > V6Entries) ? V4Entries : V6Entries;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned KeyW = 256;
  localparam int unsigned RowW = KeyW + 128;

  localparam logic [15:0] EthHdrBytes = 16'd14;
  localparam logic [15:0] V4MinBytes  = 16'd34;
  localparam logic [15:0] V6MinBytes  = 16'd54;
  localparam logic [15:0] TypeV4      = 16'h0800;
  localparam logic [15:0] TypeV6      = 16'h86DD;

  localparam logic [1:0] VerdictPass  = 2'd0;
  localparam logic [1:0] VerdictDrop  = 2'd1;
  localparam logic [1:0] VerdictAbort = 2'd2;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindV4   = 2'd1;
  localparam logic [1:0] KindV6   = 2'd2;

  localparam logic [1:0] StNone    = 2'd0;
  localparam logic [1:0] StNew     = 2'd1;
  localparam logic [1:0] StUpdated = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;
endpackage

### rtl/core/ipfc_ram.sv
// generic single-port ram with registered read
module ipfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### rtl/core/ip_flow_packet_byte_counter_top.sv
// top level of the ip flow packet and byte counter
//
// one frame word in, one result word out. tracked frames (ipv4 / ipv6 long
// enough) scan their family's flow table in ram: entries are filled densely
// from slot 0 and never removed, so a fill count replaces per-entry valid
// bits and the first free slot is always the fill count. the scan reads one
// entry per cycle from a single-port ram with registered read, so a tracked
// frame compares at most n entries, where n is the current number of entries
// of its family (up to 1024), and a hit adds a counter write-back. untracked,
// dropped and aborted frames skip the scan. a finished frame waits in the
// done state while the previous result word is still stalled at the output.
// a new entry is written with zero counts and reports zero; a full table with
// no match reports status 3. a finished result sits in the output register
// while the next frame is accepted. the ram holds address key and both 64-bit
// counters in one row; there is no clearing pass after reset.
`include "ip_flow_packet_byte_counter_top_assert.svh"
module ip_flow_packet_byte_counter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] ethertype_i,
  input  logic [15:0] frame_length_i,
  input  logic [63:0] src_addr_hi_i,
  input  logic [63:0] src_addr_lo_i,
  input  logic [63:0] dst_addr_hi_i,
  input  logic [63:0] dst_addr_lo_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [1:0]  flow_kind_o,
  output logic [1:0]  flow_status_o,
  output logic [63:0] packet_count_o,
  output logic [63:0] byte_count_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CMP, S_WRITE, S_DONE
  } state_e;

  state_e state_q;
  logic [ipfc_pkg::CntW-1:0] v4_cnt_q, v6_cnt_q, idx_q, lim_q;
  logic [ipfc_pkg::KeyW-1:0] key_q;
  logic [15:0] len_q;
  logic        v6_q;
  logic [1:0]  verdict_q, kind_q, status_q;
  logic [63:0] pk_q, by_q;
  logic        out_valid_q;

  // ram control
  logic                        v4_we, v6_we;
  logic [ipfc_pkg::V4IdxW-1:0] v4_addr;
  logic [ipfc_pkg::V6IdxW-1:0] v6_addr;
  logic [ipfc_pkg::RowW-1:0]   wrow, v4_rd, v6_rd, rd;
  logic [ipfc_pkg::CntW-1:0]   addr_idx;
  logic [63:0]                 pk_inc, by_inc;

  ipfc_ram #(.Width(ipfc_pkg::RowW), .Depth(ipfc_pkg::V4Entries)) u_v4_ram (
    .clk_i(clk_i), .we_i(v4_we), .addr_i(v4_addr), .wdata_i(wrow), .rdata_o(v4_rd)
  );
  ipfc_ram #(.Width(ipfc_pkg::RowW), .Depth(ipfc_pkg::V6Entries)) u_v6_ram (
    .clk_i(clk_i), .we_i(v6_we), .addr_i(v6_addr), .wdata_i(wrow), .rdata_o(v6_rd)
  );

  assign rd     = v6_q ? v6_rd : v4_rd;
  assign pk_inc = rd[127:64] + 64'd1;
  assign by_inc = rd[63:0] + {48'd0, len_q};

  logic in_acc, out_acc, hit;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign hit     = (rd[ipfc_pkg::RowW-1:128] == key_q);

  assign in_stall_o = (state_q != S_IDLE);

  // output word handover: load when the register is empty or drains now
  logic out_load, out_valid_d;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_acc);
  assign out_valid_d = out_load || (out_valid_q && !out_acc);

  // frame classification from the input word
  logic [1:0] verdict_d, kind_d;
  always_comb begin
    verdict_d = ipfc_pkg::VerdictPass;
    kind_d    = ipfc_pkg::KindNone;
    if (frame_length_i < ipfc_pkg::EthHdrBytes) begin
      verdict_d = ipfc_pkg::VerdictDrop;
    end else if (ethertype_i == ipfc_pkg::TypeV4) begin
      if (frame_length_i < ipfc_pkg::V4MinBytes) begin
        verdict_d = ipfc_pkg::VerdictAbort;
      end else begin
        kind_d = ipfc_pkg::KindV4;
      end
    end else if (ethertype_i == ipfc_pkg::TypeV6) begin
      if (frame_length_i < ipfc_pkg::V6MinBytes) begin
        verdict_d = ipfc_pkg::VerdictAbort;
      end else begin
        kind_d = ipfc_pkg::KindV6;
      end
    end
  end

  always_comb begin
    addr_idx = idx_q;
    wrow     = {key_q, 128'd0};
    v4_we    = 1'b0;
    v6_we    = 1'b0;
    if (state_q == S_WRITE) begin
      // write back updated counters at the matched slot
      addr_idx = idx_q;
      wrow     = {key_q, pk_q, by_q};
      v4_we    = !v6_q;
      v6_we    = v6_q;
    end else if (state_q == S_CMP && (lim_q == '0 || !hit) && (idx_q + 1'b1 >= lim_q)
                 && lim_q < (v6_q ? ipfc_pkg::CntW'(ipfc_pkg::V6Entries)
                                  : ipfc_pkg::CntW'(ipfc_pkg::V4Entries))) begin
      // no match: append new entry at the fill count
      addr_idx = lim_q;
      v4_we    = !v6_q;
      v6_we    = v6_q;
    end else if (state_q == S_CMP) begin
      addr_idx = idx_q + 1'b1;
    end
    v4_addr = addr_idx[ipfc_pkg::V4IdxW-1:0];
    v6_addr = addr_idx[ipfc_pkg::V6IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      v4_cnt_q    <= '0;
      v6_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            len_q     <= frame_length_i;
            verdict_q <= verdict_d;
            kind_q    <= kind_d;
            status_q  <= ipfc_pkg::StNone;
            pk_q      <= '0;
            by_q      <= '0;
            idx_q     <= '0;
            state_q   <= (kind_d != ipfc_pkg::KindNone) ? S_READ : S_DONE;
            if (ethertype_i == ipfc_pkg::TypeV6) begin
              v6_q  <= 1'b1;
              key_q <= {src_addr_hi_i, src_addr_lo_i, dst_addr_hi_i, dst_addr_lo_i};
              lim_q <= v6_cnt_q;
            end else begin
              v6_q  <= 1'b0;
              key_q <= {192'd0, src_addr_lo_i[31:0], dst_addr_lo_i[31:0]};
              lim_q <= v4_cnt_q;
            end
          end
        end
        S_READ: begin
          // ram address idx_q is being presented; data arrives next cycle
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (lim_q != '0 && hit) begin
            pk_q     <= pk_inc;
            by_q     <= by_inc;
            status_q <= ipfc_pkg::StUpdated;
            state_q  <= S_WRITE;
          end else if (lim_q == '0 || idx_q + 1'b1 >= lim_q) begin
            if (lim_q < (v6_q ? ipfc_pkg::CntW'(ipfc_pkg::V6Entries)
                              : ipfc_pkg::CntW'(ipfc_pkg::V4Entries))) begin
              status_q <= ipfc_pkg::StNew;
              if (v6_q) v6_cnt_q <= v6_cnt_q + 1'b1;
              else      v4_cnt_q <= v4_cnt_q + 1'b1;
            end else begin
              status_q <= ipfc_pkg::StFull;
            end
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_CMP;
          end
        end
        S_WRITE: state_q <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result register, loaded when the result is handed over
  logic [1:0]  r_verdict_q, r_kind_q, r_status_q;
  logic [63:0] r_pk_q, r_by_q;
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      r_verdict_q <= verdict_q;
      r_kind_q    <= kind_q;
      r_status_q  <= status_q;
      r_pk_q      <= pk_q;
      r_by_q      <= by_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = r_verdict_q;
  assign flow_kind_o    = r_kind_q;
  assign flow_status_o  = r_status_q;
  assign packet_count_o = r_pk_q;
  assign byte_count_o   = r_by_q;

  `IPFC_ASSERT_IMP(a_v4_cnt_bound, clk_i, rst_ni, 1'b1,
    v4_cnt_q <= ipfc_pkg::CntW'(ipfc_pkg::V4Entries))
  `IPFC_ASSERT_IMP(a_v6_cnt_bound, clk_i, rst_ni, 1'b1,
    v6_cnt_q <= ipfc_pkg::CntW'(ipfc_pkg::V6Entries))
  `IPFC_ASSERT_IMP(a_one_ram_write, clk_i, rst_ni, 1'b1, !(v4_we && v6_we))
  `IPFC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_acc, in_stall_o)
endmodule

### bench/ip_flow_packet_byte_counter_top_tb.sv
// self-checking bench for the ip flow packet and byte counter
`timescale 1ns / 1ps
module ip_flow_packet_byte_counter_top_tb;

  // one frame word as offered on the input channel
  typedef struct packed {
    logic [15:0] ethertype;
    logic [15:0] frame_length;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
  } frame_t;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [1:0]  verdict;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] packets;
    logic [63:0] bytes;
  } tally_t;

  localparam int unsigned PoolSize = 24;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] ethertype_i;
  logic [15:0] frame_length_i;
  logic [63:0] src_addr_hi_i;
  logic [63:0] src_addr_lo_i;
  logic [63:0] dst_addr_hi_i;
  logic [63:0] dst_addr_lo_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  verdict_o;
  logic [1:0]  flow_kind_o;
  logic [1:0]  flow_status_o;
  logic [63:0] packet_count_o;
  logic [63:0] byte_count_o;

  ip_flow_packet_byte_counter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ethertype_i    (ethertype_i),
    .frame_length_i (frame_length_i),
    .src_addr_hi_i  (src_addr_hi_i),
    .src_addr_lo_i  (src_addr_lo_i),
    .dst_addr_hi_i  (dst_addr_hi_i),
    .dst_addr_lo_i  (dst_addr_lo_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .flow_kind_o    (flow_kind_o),
    .flow_status_o  (flow_status_o),
    .packet_count_o (packet_count_o),
    .byte_count_o   (byte_count_o)
  );

  // frames waiting for the driver, results waiting for the monitor
  frame_t pending_frames[$];
  tally_t expected_tallies[$];

  // shadow flow tables: key -> counters, entry count is the map size
  logic [63:0] v4_packets[logic [63:0]];
  logic [63:0] v4_bytes[logic [63:0]];
  logic [63:0] v6_packets[logic [255:0]];
  logic [63:0] v6_bytes[logic [255:0]];

  // address pools so that flows recur and tables stay short
  logic [63:0] v4_pool_src[PoolSize];
  logic [63:0] v4_pool_dst[PoolSize];
  logic [255:0] v6_pool[PoolSize];

  int unsigned errors;
  int unsigned frames_accepted;
  int unsigned idle_cycles;
  logic in_fire;
  logic out_fire;

  // clock, 12 ns period
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // apply one frame to the shadow tables and return the result it earns
  function automatic tally_t count_frame(frame_t f);
    tally_t t;
    logic [63:0] pair;
    logic [255:0] key;
    t = '0;
    t.verdict = ipfc_pkg::VerdictPass;
    t.kind = ipfc_pkg::KindNone;
    t.status = ipfc_pkg::StNone;
    if (f.frame_length < ipfc_pkg::EthHdrBytes) begin
      t.verdict = ipfc_pkg::VerdictDrop;
    end else if (f.ethertype == ipfc_pkg::TypeV4) begin
      if (f.frame_length < ipfc_pkg::V4MinBytes) begin
        t.verdict = ipfc_pkg::VerdictAbort;
      end else begin
        // upper halves are ignored for ipv4
        pair = {f.src_lo[31:0], f.dst_lo[31:0]};
        t.kind = ipfc_pkg::KindV4;
        if (v4_packets.exists(pair)) begin
          v4_packets[pair] = v4_packets[pair] + 64'd1;
          v4_bytes[pair] = v4_bytes[pair] + 64'(f.frame_length);
          t.status = ipfc_pkg::StUpdated;
          t.packets = v4_packets[pair];
          t.bytes = v4_bytes[pair];
        end else if (v4_packets.num() >= ipfc_pkg::V4Entries) begin
          t.status = ipfc_pkg::StFull;
        end else begin
          v4_packets[pair] = '0;
          v4_bytes[pair] = '0;
          t.status = ipfc_pkg::StNew;
        end
      end
    end else if (f.ethertype == ipfc_pkg::TypeV6) begin
      if (f.frame_length < ipfc_pkg::V6MinBytes) begin
        t.verdict = ipfc_pkg::VerdictAbort;
      end else begin
        key = {f.src_hi, f.src_lo, f.dst_hi, f.dst_lo};
        t.kind = ipfc_pkg::KindV6;
        if (v6_packets.exists(key)) begin
          v6_packets[key] = v6_packets[key] + 64'd1;
          v6_bytes[key] = v6_bytes[key] + 64'(f.frame_length);
          t.status = ipfc_pkg::StUpdated;
          t.packets = v6_packets[key];
          t.bytes = v6_bytes[key];
        end else if (v6_packets.num() >= ipfc_pkg::V6Entries) begin
          t.status = ipfc_pkg::StFull;
        end else begin
          v6_packets[key] = '0;
          v6_bytes[key] = '0;
          t.status = ipfc_pkg::StNew;
        end
      end
    end
    return t;
  endfunction

  task automatic queue_frame(input logic [15:0] et, input logic [15:0] len,
                             input logic [63:0] sh, input logic [63:0] sl,
                             input logic [63:0] dh, input logic [63:0] dl);
    frame_t f;
    f.ethertype = et;
    f.frame_length = len;
    f.src_hi = sh;
    f.src_lo = sl;
    f.dst_hi = dh;
    f.dst_lo = dl;
    pending_frames.push_back(f);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // block until every queued frame went in and every result came back
  task automatic drain();
    while (pending_frames.size() != 0 || in_valid_i || expected_tallies.size() != 0)
      @(posedge clk_i);
  endtask

  // one random frame, mostly well-formed tracked traffic on the pools
  task automatic queue_random_frame();
    int unsigned sel;
    int unsigned p;
    logic [255:0] k;
    sel = $urandom_range(99);
    p = $urandom_range(PoolSize - 1);
    if (sel < 40) begin
      queue_frame(ipfc_pkg::TypeV4, 16'($urandom_range(65535, 34)), rand64(),
                  {$urandom, v4_pool_src[p][31:0]}, rand64(),
                  {$urandom, v4_pool_dst[p][31:0]});
    end else if (sel < 75) begin
      k = v6_pool[p];
      queue_frame(ipfc_pkg::TypeV6, 16'($urandom_range(65535, 54)),
                  k[255:192], k[191:128], k[127:64], k[63:0]);
    end else if (sel < 80) begin
      // fresh flows now and then
      if ($urandom_range(1))
        queue_frame(ipfc_pkg::TypeV4, 16'($urandom_range(1500, 34)), rand64(),
                    rand64(), rand64(), rand64());
      else
        queue_frame(ipfc_pkg::TypeV6, 16'($urandom_range(1500, 54)), rand64(),
                    rand64(), rand64(), rand64());
    end else if (sel < 88) begin
      // truncated headers around the thresholds
      if ($urandom_range(1))
        queue_frame(ipfc_pkg::TypeV4, 16'($urandom_range(40)), rand64(), rand64(),
                    rand64(), rand64());
      else
        queue_frame(ipfc_pkg::TypeV6, 16'($urandom_range(60)), rand64(), rand64(),
                    rand64(), rand64());
    end else begin
      // noise: any ethertype, any length
      queue_frame(16'($urandom), 16'($urandom), rand64(), rand64(), rand64(),
                  rand64());
    end
  endtask

  // driver: bursts of random length with random gaps, changes at falling edge
  int unsigned burst_left;
  int unsigned gap_left;
  frame_t next_frame;

  always @(posedge clk_i) begin
    in_fire <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      expected_tallies.push_back(count_frame({ethertype_i, frame_length_i,
        src_addr_hi_i, src_addr_lo_i, dst_addr_hi_i, dst_addr_lo_i}));
      frames_accepted <= frames_accepted + 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_frames.size() != 0) begin
        next_frame = pending_frames.pop_front();
        in_valid_i <= 1'b1;
        ethertype_i <= next_frame.ethertype;
        frame_length_i <= next_frame.frame_length;
        src_addr_hi_i <= next_frame.src_hi;
        src_addr_lo_i <= next_frame.src_lo;
        dst_addr_hi_i <= next_frame.dst_hi;
        dst_addr_lo_i <= next_frame.dst_lo;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(40, 1);
          // some bursts run back to back with no gap at all
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result word with the oldest expectation
  tally_t seen;
  tally_t want;

  always @(posedge clk_i) begin
    out_fire <= out_valid_o && !out_stall_i;
    if (out_valid_o && !out_stall_i) begin
      seen = {verdict_o, flow_kind_o, flow_status_o, packet_count_o, byte_count_o};
      if (expected_tallies.size() == 0) begin
        $display("%0t: unexpected result word verdict=%0d kind=%0d status=%0d",
                 $time, seen.verdict, seen.kind, seen.status);
        errors <= errors + 1;
      end else begin
        want = expected_tallies.pop_front();
        if (seen !== want) begin
          $display("%0t: verdict exp %0d got %0d, kind exp %0d got %0d", $time,
                   want.verdict, seen.verdict, want.kind, seen.kind);
          $display("%0t: status exp %0d got %0d, packets exp %0h got %0h", $time,
                   want.status, seen.status, want.packets, seen.packets);
          $display("%0t: bytes exp %0h got %0h", $time, want.bytes, seen.bytes);
          errors <= errors + 1;
        end
      end
    end
  end

  // receiver stall pattern: a random mode redrawn on the phase counter, plus one long hold
  int unsigned stall_phase;
  int unsigned stall_mode;
  int unsigned hold_left;
  logic hold_done;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0)
        stall_mode <= $urandom_range(3);
      if (!hold_done && frames_accepted >= 300) begin
        // long hold while the sender keeps offering, so the input backs up
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(9) < 3);
          2: out_stall_i <= ($urandom_range(9) < 7);
          default: out_stall_i <= stall_phase[0];
        endcase
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (in_fire || out_fire || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b1;
    ethertype_i = '0;
    frame_length_i = '0;
    src_addr_hi_i = '0;
    src_addr_lo_i = '0;
    dst_addr_hi_i = '0;
    dst_addr_lo_i = '0;
    errors = 0;
    frames_accepted = 0;
    idle_cycles = 0;
    in_fire = 1'b0;
    out_fire = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_phase = 0;
    stall_mode = 0;
    hold_left = 0;
    hold_done = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      v4_pool_src[i] = rand64();
      v4_pool_dst[i] = rand64();
      v6_pool[i] = {rand64(), rand64(), rand64(), rand64()};
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: length thresholds, both families, repeats, untracked types
    queue_frame(ipfc_pkg::TypeV4, 16'd0, '0, '0, '0, '0);
    queue_frame(ipfc_pkg::TypeV4, 16'd13, '1, '1, '1, '1);
    queue_frame(ipfc_pkg::TypeV4, 16'd14, '0, 64'h1, '0, 64'h2);
    queue_frame(ipfc_pkg::TypeV4, 16'd33, '0, 64'h1, '0, 64'h2);
    queue_frame(ipfc_pkg::TypeV4, 16'd34, '0, 64'h1, '0, 64'h2);
    queue_frame(ipfc_pkg::TypeV4, 16'd65535, '0, 64'h1, '0, 64'h2);
    // same ipv4 pair with junk in the ignored upper bits: still one flow
    queue_frame(ipfc_pkg::TypeV4, 16'd100, '1, 64'hFFFF_FFFF_0000_0001, '1,
                64'hABCD_0123_0000_0002);
    queue_frame(ipfc_pkg::TypeV4, 16'd34, '0, 64'hFFFF_FFFF, '0, 64'hFFFF_FFFF);
    queue_frame(ipfc_pkg::TypeV4, 16'd65535, '0, 64'hFFFF_FFFF, '0, 64'hFFFF_FFFF);
    queue_frame(ipfc_pkg::TypeV6, 16'd13, '0, '0, '0, '0);
    queue_frame(ipfc_pkg::TypeV6, 16'd14, '0, '0, '0, '0);
    queue_frame(ipfc_pkg::TypeV6, 16'd53, '1, '1, '1, '1);
    queue_frame(ipfc_pkg::TypeV6, 16'd54, '1, '1, '1, '1);
    queue_frame(ipfc_pkg::TypeV6, 16'd65535, '1, '1, '1, '1);
    queue_frame(ipfc_pkg::TypeV6, 16'd54, '0, '0, '0, '0);
    queue_frame(ipfc_pkg::TypeV6, 16'd54, '0, '0, '0, '0);
    // an ipv6 flow differing from the last only in the upper source half
    queue_frame(ipfc_pkg::TypeV6, 16'd60, 64'h1, '0, '0, '0);
    queue_frame(16'h0000, 16'd14, '1, '1, '1, '1);
    queue_frame(16'hFFFF, 16'd65535, '1, '1, '1, '1);
    queue_frame(16'h86DC, 16'd100, '0, '0, '0, '0);
    queue_frame(16'h0801, 16'd100, '0, '0, '0, '0);
    queue_frame(16'hFFFF, 16'd0, '0, '0, '0, '0);
    drain();

    // random traffic, with one pause in the middle until all results are back
    for (int i = 0; i < 720; i++) begin
      if (i == 360)
        drain();
      queue_random_frame();
      while (pending_frames.size() > 64)
        @(posedge clk_i);
    end
    drain();

    // fill the ipv4 table with fresh flows until it reports full
    for (int i = 0; i < 1030; i++) begin
      queue_frame(ipfc_pkg::TypeV4, 16'($urandom_range(1500, 34)), '0,
                  64'(i + 32'hC000_0000), '0, 64'($urandom));
      while (pending_frames.size() > 16)
        @(posedge clk_i);
    end
    // a known flow must still update once the table is full
    queue_frame(ipfc_pkg::TypeV4, 16'd200, '0, 64'h1, '0, 64'h2);
    drain();

    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_tallies.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
